FILE: hw/rtl/c2a_pkg.sv
// ---------------------------------------------------------------------------
// c2a_pkg
// Shared types and codes for the streaming KxK convolution with accumulate.
// ---------------------------------------------------------------------------
package c2a_pkg;

   localparam int SUM_BITS   = 40;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR   = 3;
   localparam int FIFO_CNT   = 4;

   localparam logic FUNC_WEIGHT = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      CSR_KERNEL_SIZE = 2'd0,
      CSR_OUT_WIDTH   = 2'd1,
      CSR_OUT_HEIGHT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               func;
      logic [4:0]         weight_index;
      logic signed [15:0] weight_value;
      logic signed [15:0] sample;
      logic signed [39:0] prior_sum;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic signed [39:0] out_sum;
      logic [15:0]        out_row;
      logic [9:0]         out_col;
   } rsp_type;

   // Per-cycle control handed to every cell of the row.
   typedef struct packed {
      logic       shift;
      logic [2:0] k;
   } cell_ctl_type;

endpackage

FILE: hw/rtl/c2a_ram.sv
// ---------------------------------------------------------------------------
// c2a_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module c2a_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1028
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/c2a_cell.sv
// ---------------------------------------------------------------------------
// c2a_cell
// One kernel row: its line buffer (none on the last row), its window row, products and row sum.
// ---------------------------------------------------------------------------
module c2a_cell #(
   parameter int ROW         = 0,
   parameter int MAX_KERNEL  = 5,
   parameter int SAMPLE_BITS = 16,
   parameter int LINE_DEPTH  = 1028,
   parameter int SUM_W       = 2 * SAMPLE_BITS + 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  c2a_pkg::cell_ctl_type                  ctl,
   input  logic [$clog2(LINE_DEPTH)-1:0]          rd_addr,
   input  logic [$clog2(LINE_DEPTH)-1:0]          wr_addr,
   input  logic [SAMPLE_BITS-1:0]                 sample,
   input  logic [SAMPLE_BITS-1:0]                 up_line,
   input  logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] weight_row,
   output logic [SAMPLE_BITS-1:0]                 line_out,
   output logic signed [SUM_W-1:0]                row_sum
);
   import c2a_pkg::*;

   localparam int PW = 2 * SAMPLE_BITS;

   logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] win_ff, win_in;
   logic signed [PW-1:0] prod_ff [MAX_KERNEL];
   logic signed [SUM_W-1:0] row_sum_ff, row_sum_in;
   logic [SAMPLE_BITS-1:0] new_val;
   logic row_act;

   generate
      if (ROW < MAX_KERNEL - 1) begin : g_line
         logic line_wr;
         logic [SAMPLE_BITS-1:0] line_wd, ram_q, fwd_ff;
         logic hit_ff, hit_in;

         // this row takes the row below it, the lowest used row takes the sample
         assign line_wr = ctl.shift && ((4'(ROW) + 4'd2) <= {1'b0, ctl.k});
         assign line_wd = ((4'(ROW) + 4'd2) == {1'b0, ctl.k}) ? sample : up_line;
         assign hit_in  = line_wr && (wr_addr == rd_addr);

         c2a_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LINE_DEPTH)) u_ram (
            .clock   (clock),
            .wr_en   (line_wr),
            .wr_addr (wr_addr),
            .wr_data (line_wd),
            .rd_addr (rd_addr),
            .rd_data (ram_q)
         );

         // read and write of one column in the same cycle: pass the new value on
         always_ff @(posedge clock) begin
            if (reset) begin
               hit_ff <= 1'b0;
            end else begin
               hit_ff <= hit_in;
            end
            fwd_ff <= line_wd;
         end

         assign line_out = hit_ff ? fwd_ff : ram_q;
      end else begin : g_noline
         assign line_out = '0;
      end
   endgenerate

   assign row_act = ctl.shift && (4'(ROW) < {1'b0, ctl.k});
   assign new_val = ((4'(ROW) + 4'd1) == {1'b0, ctl.k}) ? sample : line_out;

   genvar dx;
   generate
      for (dx = 0; dx < MAX_KERNEL; dx++) begin : g_win
         logic [SAMPLE_BITS-1:0] right;
         if (dx < MAX_KERNEL - 1) begin : g_mid
            assign right = win_ff[dx+1];
         end else begin : g_end
            assign right = win_ff[dx];
         end
         always_comb begin
            win_in[dx] = win_ff[dx];
            if (row_act && ((4'(dx) + 4'd1) < {1'b0, ctl.k})) begin
               win_in[dx] = right;
            end else if (row_act && ((4'(dx) + 4'd1) == {1'b0, ctl.k})) begin
               win_in[dx] = new_val;
            end
         end
      end
   endgenerate

   always_comb begin
      row_sum_in = '0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
         row_sum_in = row_sum_in + SUM_W'(prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
      for (int i = 0; i < MAX_KERNEL; i++) begin
         prod_ff[i] <= $signed(win_ff[i]) * $signed(weight_row[i]);
      end
      row_sum_ff <= row_sum_in;
   end

   assign row_sum = row_sum_ff;
endmodule

FILE: hw/rtl/conv2d_add_forward_top.sv
// ---------------------------------------------------------------------------
// conv2d_add_forward_top
// Streaming valid KxK convolution with accumulate, row of kernel-row cells.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | req_data  (c2a_pkg::req_type)
//  rsp     | out       | rsp_valid/stall    | rsp_data  (c2a_pkg::rsp_type)
//  csr     | in        | csr_valid/ready    | csr_index, csr_data
//
//  One item per cycle while req_stall is low. A result leaves after its sample
//  transfer has passed the line buffer read, window, multiply, row sum and
//  final add stages. Up to 8 results are held; req_stall rises while 8 results
//  are in flight. Reset clears counters, window and weights; line buffers are
//  not cleared. csr_ready is always high.
module conv2d_add_forward_top #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_KERNEL  = 5,
   parameter int SAMPLE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  c2a_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output c2a_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import c2a_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH + MAX_KERNEL - 1;
   localparam int AB  = $clog2(LINE_DEPTH);
   localparam int CW  = $clog2(MAX_WIDTH + MAX_KERNEL);
   localparam int WN  = MAX_KERNEL * MAX_KERNEL;
   localparam int WI  = $clog2(WN);
   localparam int RSW = 2 * SAMPLE_BITS + $clog2(MAX_KERNEL) + 1;
   localparam int TSW = RSW + $clog2(MAX_KERNEL) + 1;
   localparam int AW  = (TSW > SUM_BITS ? TSW : SUM_BITS) + 1;
   localparam logic signed [AW-1:0] SAT_HI = {{(AW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [AW-1:0] SAT_LO = {{(AW-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};

   // configuration
   logic [2:0]  kernel_ff;
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  k_eff;
   logic [CW-1:0] w_eff, len;
   logic [16:0] rows;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= 3'd3;
         width_ff  <= 11'd1024;
         height_ff <= 16'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KERNEL_SIZE: kernel_ff <= csr_data[2:0];
            CSR_OUT_WIDTH:   width_ff  <= csr_data[10:0];
            CSR_OUT_HEIGHT:  height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (kernel_ff < 3'd2) begin
         k_eff = 3'd2;
      end else if (32'(kernel_ff) > 32'(MAX_KERNEL)) begin
         k_eff = 3'(MAX_KERNEL);
      end else begin
         k_eff = kernel_ff;
      end
      if (width_ff == 11'd0) begin
         w_eff = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      len  = w_eff + CW'(k_eff) - CW'(1);
      rows = ((height_ff == 16'd0) ? 17'd1 : {1'b0, height_ff}) + 17'(k_eff) - 17'd1;
   end

   // position counters and accept
   logic accept, res0;
   logic [CW-1:0] col_ff, col_in, col0, col1, col2;
   logic [16:0]   row_ff, row_in, row0, row1, row2;
   logic [15:0]   orow0;
   logic [9:0]    ocol0;
   logic [FIFO_CNT-1:0] pending_ff, pending_in;
   logic rsp_xfer, is_sample;

   assign req_stall = (pending_ff == FIFO_CNT'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign is_sample = (req_data.func == FUNC_SAMPLE);

   always_comb begin
      col0 = req_data.frame_start ? '0 : col_ff;
      row0 = req_data.frame_start ? '0 : row_ff;
      col1 = col0;
      row1 = row0;
      if (col0 >= len) begin
         col1 = '0;
         row1 = row0 + 17'd1;
      end
      if (row1 >= rows) begin
         row1 = '0;
      end
      res0  = (row1 >= 17'(k_eff - 3'd1)) && (col1 >= CW'(k_eff - 3'd1));
      orow0 = 16'(row1 - 17'(k_eff) + 17'd1);
      ocol0 = 10'(32'(col1) - 32'(k_eff) + 32'd1);
      col2  = col1 + CW'(1);
      row2  = row1;
      if (col2 >= len) begin
         col2 = '0;
         row2 = row1 + 17'd1;
         if (row2 >= rows) begin
            row2 = '0;
         end
      end
      col_in = col_ff;
      row_in = row_ff;
      if (accept && is_sample) begin
         col_in = col2;
         row_in = row2;
      end
   end

   assign rsp_xfer   = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + FIFO_CNT'(accept && is_sample && res0)
                                  - FIFO_CNT'(rsp_xfer);

   // pipeline tags
   logic s1_ff, s2_ff, s3_ff, s4_ff;
   logic r1_ff, r2_ff, r3_ff, r4_ff;
   logic w1_ff, w2_ff;
   logic [AB-1:0] c1_ff;
   logic [SAMPLE_BITS-1:0] smp1_ff;
   logic [4:0]  wi1_ff, wi2_ff;
   logic [SAMPLE_BITS-1:0] wv1_ff, wv2_ff;
   logic signed [39:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic [15:0] or1_ff, or2_ff, or3_ff, or4_ff;
   logic [9:0]  oc1_ff, oc2_ff, oc3_ff, oc4_ff;
   logic [WN-1:0][SAMPLE_BITS-1:0] weight_ff;
   logic [SAMPLE_BITS-1:0] smp0, wv0;

   assign smp0 = SAMPLE_BITS'(32'(unsigned'(req_data.sample)));
   assign wv0  = SAMPLE_BITS'(32'(unsigned'(req_data.weight_value)));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         pending_ff <= '0;
         s1_ff <= 1'b0; s2_ff <= 1'b0; s3_ff <= 1'b0; s4_ff <= 1'b0;
         w1_ff <= 1'b0; w2_ff <= 1'b0;
         weight_ff  <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         pending_ff <= pending_in;
         s1_ff <= accept && is_sample;
         w1_ff <= accept && !is_sample;
         s2_ff <= s1_ff; s3_ff <= s2_ff; s4_ff <= s3_ff;
         w2_ff <= w1_ff;
         // weights change in order with the products that read them
         if (w2_ff && (32'(wi2_ff) < WN)) begin
            weight_ff[WI'(wi2_ff)] <= wv2_ff;
         end
      end
      r1_ff <= res0; r2_ff <= r1_ff; r3_ff <= r2_ff; r4_ff <= r3_ff;
      c1_ff   <= col1[AB-1:0];
      smp1_ff <= smp0;
      wi1_ff  <= req_data.weight_index; wi2_ff <= wi1_ff;
      wv1_ff  <= wv0;                   wv2_ff <= wv1_ff;
      p1_ff   <= req_data.prior_sum; p2_ff <= p1_ff; p3_ff <= p2_ff; p4_ff <= p3_ff;
      or1_ff  <= orow0; or2_ff <= or1_ff; or3_ff <= or2_ff; or4_ff <= or3_ff;
      oc1_ff  <= ocol0; oc2_ff <= oc1_ff; oc3_ff <= oc2_ff; oc4_ff <= oc3_ff;
   end

   // row of cells
   cell_ctl_type ctl;
   logic [SAMPLE_BITS-1:0] line_q [MAX_KERNEL+1];
   logic signed [RSW-1:0]  rsum [MAX_KERNEL];

   assign ctl.shift = s1_ff;
   assign ctl.k     = k_eff;
   assign line_q[MAX_KERNEL] = '0;

   genvar dy;
   generate
      for (dy = 0; dy < MAX_KERNEL; dy++) begin : g_cell
         logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] wrow;
         always_comb begin
            for (int dx = 0; dx < MAX_KERNEL; dx++) begin
               if ((dy < int'(k_eff)) && (dx < int'(k_eff))) begin
                  wrow[dx] = weight_ff[WI'(dy * int'(k_eff) + dx)];
               end else begin
                  wrow[dx] = '0;
               end
            end
         end
         c2a_cell #(
            .ROW         (dy),
            .MAX_KERNEL  (MAX_KERNEL),
            .SAMPLE_BITS (SAMPLE_BITS),
            .LINE_DEPTH  (LINE_DEPTH),
            .SUM_W       (RSW)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .rd_addr    (col1[AB-1:0]),
            .wr_addr    (c1_ff),
            .sample     (smp1_ff),
            .up_line    (line_q[dy+1]),
            .weight_row (wrow),
            .line_out   (line_q[dy]),
            .row_sum    (rsum[dy])
         );
      end
   endgenerate

   // final add and saturation
   logic signed [AW-1:0] total;
   rsp_type res4;

   always_comb begin
      total = AW'(p4_ff);
      for (int i = 0; i < MAX_KERNEL; i++) begin
         total = total + AW'(rsum[i]);
      end
      if (total > SAT_HI) begin
         total = SAT_HI;
      end else if (total < SAT_LO) begin
         total = SAT_LO;
      end
      res4.out_sum = total[SUM_BITS-1:0];
      res4.out_row = or4_ff;
      res4.out_col = oc4_ff;
   end

   // result queue
   rsp_type fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR-1:0] wp_ff, rp_ff;
   logic [FIFO_CNT-1:0] cnt_ff;
   logic push;

   assign push = s4_ff && r4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_ff + FIFO_PTR'(push);
         rp_ff  <= rp_ff + FIFO_PTR'(rsp_xfer);
         cnt_ff <= cnt_ff + FIFO_CNT'(push) - FIFO_CNT'(rsp_xfer);
      end
      if (push) begin
         fifo_ff[wp_ff] <= res4;
      end
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = fifo_ff[rp_ff];
endmodule

FILE: hw/rtl/c2a_checker.sv
// ---------------------------------------------------------------------------
// c2a_checker
// Port-level checks for conv2d_add_forward_top, bound to the top level.
// ---------------------------------------------------------------------------
module c2a_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input c2a_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input c2a_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [1:0]       csr_index,
   input logic [15:0]      csr_data
);
   import c2a_pkg::*;

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // queue empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result comes from an earlier sample transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && (req_data.func == FUNC_SAMPLE), 5))
      else $error("result without matching sample transfer");

   // register writes are never held off
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");
endmodule

bind conv2d_add_forward_top c2a_checker u_c2a_checker (.*);

FILE: tb/conv2d_add_forward_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conv2d_add_forward_top_tb
// Self-checking bench for the streaming KxK convolution with accumulate.
// A scoreboard class predicts each result from the accepted transfers and
// compares the results in order. Directed phases cover register extremes,
// out-of-range settings, ignored weight indexes and saturation; then random
// frames run. Three sender/receiver idle mixes span the whole run.
// ---------------------------------------------------------------------------
module conv2d_add_forward_top_tb;
   import c2a_pkg::*;

   localparam int LINE_COLS  = 1028;
   localparam int WD_LIMIT   = 4000;
   localparam int RAND_ITEMS = 1750;

   class conv_scoreboard;
      logic [15:0] coeff [25];
      logic [15:0] lines [4][LINE_COLS];
      logic [15:0] win [25];
      int unsigned col, row;
      logic [2:0]  k_reg;
      logic [10:0] w_reg;
      logic [15:0] h_reg;
      rsp_type     sums_q [$];
      int          errors;

      function void clear();
         foreach (coeff[i]) coeff[i] = '0;
         foreach (win[i]) win[i] = '0;
         foreach (lines[i, j]) lines[i][j] = '0;
         col = 0;
         row = 0;
         k_reg = 3'd3;
         w_reg = 11'd1024;
         h_reg = 16'd1;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] d);
         case (idx)
            CSR_KERNEL_SIZE: k_reg = d[2:0];
            CSR_OUT_WIDTH:   w_reg = d[10:0];
            CSR_OUT_HEIGHT:  h_reg = d;
            default: ;
         endcase
      endfunction

      function int unsigned eff_k();
         return (k_reg < 2) ? 2 : (k_reg > 5) ? 5 : k_reg;
      endfunction

      function int unsigned row_len();
         int unsigned w;
         w = (w_reg == 0) ? 1 : (w_reg > 1024) ? 1024 : w_reg;
         return w + eff_k() - 1;
      endfunction

      function int unsigned frame_rows();
         return ((h_reg == 0) ? 1 : h_reg) + eff_k() - 1;
      endfunction

      function void note_req(req_type r);
         int unsigned k, len, rows, c;
         longint acc;
         rsp_type e;
         if (r.func == FUNC_WEIGHT) begin
            if (r.weight_index < 25) coeff[r.weight_index] = r.weight_value;
            return;
         end
         k = eff_k();
         len = row_len();
         rows = frame_rows();
         if (r.frame_start) begin
            col = 0;
            row = 0;
         end
         if (col >= len) begin
            col = 0;
            row++;
         end
         if (row >= rows) row = 0;
         c = col;
         for (int dy = 0; dy < k; dy++)
            for (int dx = 0; dx + 1 < k; dx++)
               win[dy*5 + dx] = win[dy*5 + dx + 1];
         for (int dy = 0; dy + 1 < k; dy++)
            win[dy*5 + k - 1] = lines[dy][c];
         win[(k-1)*5 + k - 1] = r.sample;
         for (int dy = 0; dy + 2 < k; dy++)
            lines[dy][c] = lines[dy+1][c];
         lines[k-2][c] = r.sample;
         if (row >= k - 1 && c >= k - 1) begin
            acc = r.prior_sum;
            for (int dy = 0; dy < k; dy++)
               for (int dx = 0; dx < k; dx++)
                  acc += longint'($signed(win[dy*5 + dx])) *
                         longint'($signed(coeff[dy*k + dx]));
            if (acc > 64'sd549755813887) acc = 64'sd549755813887;
            if (acc < -64'sd549755813888) acc = -64'sd549755813888;
            e.out_sum = acc[39:0];
            e.out_row = 16'(row - (k - 1));
            e.out_col = 10'(c - (k - 1));
            sums_q.push_back(e);
         end
         col++;
         if (col >= len) begin
            col = 0;
            row++;
            if (row >= rows) row = 0;
         end
      endfunction

      function void check_rsp(rsp_type a);
         rsp_type e;
         if (sums_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", a);
            return;
         end
         e = sums_q.pop_front();
         if (a.out_sum !== e.out_sum || a.out_row !== e.out_row ||
             a.out_col !== e.out_col) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp sum %0d row %0d col %0d, got sum %0d row %0d col %0d",
                        e.out_sum, e.out_row, e.out_col, a.out_sum, a.out_row, a.out_col);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   conv_scoreboard sb;
   int send_idle_pct = 33;
   int recv_stall_pct = 73;
   int ext_pct = 10;
   int sent = 0;
   int quiet_cycles = 0;

   conv2d_add_forward_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result sink with random stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_rsp(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [15:0] pick16();
      if ($urandom_range(99) < ext_pct)
         return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      return 16'($urandom);
   endfunction

   function automatic logic [39:0] pick40();
      if ($urandom_range(99) < ext_pct)
         return $urandom_range(1) ? 40'h7F_FFFF_FFFF : 40'h80_0000_0000;
      return {8'($urandom), 32'($urandom)};
   endfunction

   // idle mix follows the share of the run already sent
   task automatic send(req_type r);
      case (sent * 3 / RAND_ITEMS)
         0: begin send_idle_pct = 33; recv_stall_pct = 73; end
         1: begin send_idle_pct = 73; recv_stall_pct = 33; end
         default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_req(r);
      sent++;
   endtask

   task automatic send_weight(logic [4:0] idx, logic [15:0] v);
      req_type r;
      r.func = FUNC_WEIGHT;
      r.weight_index = idx;
      r.weight_value = v;
      r.sample = 16'($urandom);
      r.prior_sum = pick40();
      r.frame_start = $urandom_range(1);
      send(r);
   endtask

   task automatic send_pixels(int count, bit noisy);
      req_type r;
      for (int i = 0; i < count; i++) begin
         if (noisy && $urandom_range(99) < 4)
            send_weight(5'($urandom_range(31)), pick16());
         r.func = FUNC_SAMPLE;
         r.weight_index = 5'($urandom);
         r.weight_value = 16'($urandom);
         r.sample = pick16();
         r.prior_sum = pick40();
         r.frame_start = (i == 0) || (noisy && $urandom_range(99) < 1);
         send(r);
      end
   endtask

   // wait until the block is idle, then reprogram and reload the kernel
   task automatic phase(logic [15:0] k, logic [15:0] w, logic [15:0] h);
      req_valid <= 1'b0;
      while (sb.sums_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_KERNEL_SIZE;
      csr_data <= k;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(CSR_KERNEL_SIZE, k);
      csr_index <= CSR_OUT_WIDTH;
      csr_data <= w;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(CSR_OUT_WIDTH, w);
      csr_index <= CSR_OUT_HEIGHT;
      csr_data <= h;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(CSR_OUT_HEIGHT, h);
      csr_valid <= 1'b0;
      for (int i = 0; i < 25; i++) send_weight(5'(i), pick16());
   endtask

   initial begin
      int frames;
      sb = new();
      sb.clear();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // saturation in both directions, smallest frame
      ext_pct = 100;
      phase(16'd2, 16'd1, 16'd1);
      send_weight(5'd25, 16'h7FFF);
      send_weight(5'd31, 16'h8000);
      send_pixels(4 * sb.row_len() * sb.frame_rows(), 0);
      ext_pct = 10;
      // out-of-range settings and register extremes
      phase(16'd0, 16'd0, 16'd0);
      send_pixels(2 * sb.row_len() * sb.frame_rows(), 0);
      phase(16'd7, 16'd3, 16'd0);
      send_pixels(sb.row_len() * sb.frame_rows(), 0);
      // widest row: results on the second row only appear if the width clamps
      phase(16'd1, 16'd2047, 16'd0);
      send_pixels(sb.row_len() + 8, 0);
      // tall frame: only a few rows, next frame restarts on frame_start
      phase(16'd3, 16'd4, 16'd65535);
      send_pixels(6 * sb.row_len(), 0);
      phase(16'd5, 16'd1, 16'd2);
      send_pixels(2 * sb.row_len() * sb.frame_rows(), 0);

      while (sent < RAND_ITEMS) begin
         if ($urandom_range(9) == 0)
            phase(16'($urandom_range(7)), 16'($urandom_range(40)), 16'($urandom_range(5)));
         else
            phase(16'($urandom_range(5, 2)), 16'($urandom_range(12, 1)),
                  16'($urandom_range(4, 1)));
         frames = $urandom_range(3, 1);
         for (int f = 0; f < frames; f++)
            send_pixels(sb.row_len() * sb.frame_rows(), 1);
      end

      req_valid <= 1'b0;
      while (sb.sums_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.sums_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
